@@ sv/fldt_pkg.sv @@
// ----------------------------------------------------------------------------
// Flow log dedup table package
// Shared widths, codes, state encoding and entry types for the flow log
// dedup table and its channel interfaces.
// ----------------------------------------------------------------------------
package fldt_pkg;

   // Default number of table entries.
   localparam int CAPACITY_DEFAULT = 256;

   // Field widths of one beat.
   localparam int MODE_W   = 2;
   localparam int IP_W     = 32;
   localparam int PORT_W   = 16;
   localparam int PROTO_W  = 8;
   localparam int ACTION_W = 8;
   localparam int REASON_W = 32;
   localparam int TIME_W   = 32;
   localparam int RIDX_W   = 8;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 32;

   // Request modes.
   typedef enum logic [MODE_W-1:0] {
      MODE_RECORD = 2'd0,
      MODE_READ   = 2'd1,
      MODE_CLEAR  = 2'd2
   } mode_type;

   // Response status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_NEW        = 3'd0,
      STATUS_MERGED     = 3'd1,
      STATUS_FULL       = 3'd2,
      STATUS_READ_VALID = 3'd3,
      STATUS_READ_EMPTY = 3'd4,
      STATUS_CLEARED    = 3'd5
   } status_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SEARCH,
      ST_MERGE,
      ST_APPEND,
      ST_READ_OUT,
      ST_BLANK
   } state_type;

   // The seven fields that identify a flow record.
   typedef struct packed {
      logic [IP_W-1:0]            src_ip;
      logic [IP_W-1:0]            dst_ip;
      logic [PORT_W-1:0]          source_port;
      logic [PORT_W-1:0]          dest_port;
      logic [PROTO_W-1:0]         protocol;
      logic [ACTION_W-1:0]        action;
      logic signed [REASON_W-1:0] reason;
   } tuple_type;

   // One stored table entry.
   typedef struct packed {
      tuple_type          tuple;
      logic [TIME_W-1:0]  timestamp;
      logic [COUNT_W-1:0] count;
   } entry_type;

   // One response beat.
   typedef struct packed {
      status_type        status;
      logic [RIDX_W-1:0] entry_index;
      entry_type         entry;
   } rsp_type;

endpackage

@@ sv/fldt_req_if.sv @@
// ----------------------------------------------------------------------------
// Flow log dedup table request channel
// Valid/ready channel carrying one record, read or clear request per beat.
// ----------------------------------------------------------------------------
interface fldt_req_if;

   logic                                 valid;
   logic                                 ready;
   logic [fldt_pkg::MODE_W-1:0]          mode;
   logic [fldt_pkg::IP_W-1:0]            src_ip;
   logic [fldt_pkg::IP_W-1:0]            dst_ip;
   logic [fldt_pkg::PORT_W-1:0]          source_port;
   logic [fldt_pkg::PORT_W-1:0]          dest_port;
   logic [fldt_pkg::PROTO_W-1:0]         protocol;
   logic [fldt_pkg::ACTION_W-1:0]        action;
   logic signed [fldt_pkg::REASON_W-1:0] reason;
   logic [fldt_pkg::TIME_W-1:0]          timestamp;
   logic [fldt_pkg::RIDX_W-1:0]          read_index;

   modport source (
      output valid, mode, src_ip, dst_ip, source_port, dest_port, protocol, action,
             reason, timestamp, read_index,
      input  ready
   );

   modport sink (
      input  valid, mode, src_ip, dst_ip, source_port, dest_port, protocol, action,
             reason, timestamp, read_index,
      output ready
   );

endinterface

@@ sv/fldt_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Flow log dedup table response channel
// Valid/ready channel carrying one status and entry image per beat.
// ----------------------------------------------------------------------------
interface fldt_rsp_if;

   logic                                 valid;
   logic                                 ready;
   logic [fldt_pkg::STATUS_W-1:0]        status;
   logic [fldt_pkg::RIDX_W-1:0]          entry_index;
   logic [fldt_pkg::IP_W-1:0]            out_src_ip;
   logic [fldt_pkg::IP_W-1:0]            out_dst_ip;
   logic [fldt_pkg::PORT_W-1:0]          out_source_port;
   logic [fldt_pkg::PORT_W-1:0]          out_dest_port;
   logic [fldt_pkg::PROTO_W-1:0]         out_protocol;
   logic [fldt_pkg::ACTION_W-1:0]        out_action;
   logic signed [fldt_pkg::REASON_W-1:0] out_reason;
   logic [fldt_pkg::TIME_W-1:0]          out_timestamp;
   logic [fldt_pkg::COUNT_W-1:0]         out_count;

   modport source (
      output valid, status, entry_index, out_src_ip, out_dst_ip, out_source_port,
             out_dest_port, out_protocol, out_action, out_reason, out_timestamp,
             out_count,
      input  ready
   );

   modport sink (
      input  valid, status, entry_index, out_src_ip, out_dst_ip, out_source_port,
             out_dest_port, out_protocol, out_action, out_reason, out_timestamp,
             out_count,
      output ready
   );

endinterface

@@ sv/flow_log_dedup_table.sv @@
// ----------------------------------------------------------------------------
// Flow log dedup table
// Stores firewall log records in insertion order and merges repeats of the
// same seven-field tuple into one entry with a saturating hit count and the
// latest timestamp. Entries can be read back by index and the table cleared.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake      Beat contents
//   req_if    in          valid/ready    mode, tuple, timestamp, read_index
//   rsp_if    out         valid/ready    status, entry_index, entry image
//
// A record beat scans the stored entries up to the fill level before the next
// request is taken when it ends in a new entry or a drop, and stops early on
// a match: the table memory has one read port and the tuple compare checks
// one stored entry per cycle. Read and clear beats skip the scan.
// A finished response sits in the output register, and a new request is
// accepted while it waits; the next response waits for that register to free.
// Synchronous reset empties the table (fill level zero); entry contents are
// not cleared since only entries below the fill level are ever looked at.
// ----------------------------------------------------------------------------
module flow_log_dedup_table #(
   parameter int CAPACITY = fldt_pkg::CAPACITY_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   fldt_req_if.sink       req_if,
   fldt_rsp_if.source     rsp_if
);

   localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int FILL_W = $clog2(CAPACITY + 1);
   localparam int CMP_W  = (FILL_W > fldt_pkg::RIDX_W) ? FILL_W : fldt_pkg::RIDX_W;

   // Table storage and its registered read data.
   fldt_pkg::entry_type mem [CAPACITY];
   fldt_pkg::entry_type rd_data_ff;

   // Sequencer and request registers.
   fldt_pkg::state_type state_ff, state_in;
   fldt_pkg::mode_type  mode_ff;
   fldt_pkg::tuple_type key_ff;
   logic [fldt_pkg::TIME_W-1:0] ts_ff;
   logic [fldt_pkg::RIDX_W-1:0] ridx_ff;

   // Table level, scan pointer and compare stage.
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [FILL_W-1:0] scan_ff, scan_in;
   logic [IDX_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic              cmp_valid_ff, cmp_valid_in;

   // Held status and index for responses without entry contents.
   fldt_pkg::status_type        res_status_ff, res_status_in;
   logic [fldt_pkg::RIDX_W-1:0] res_index_ff, res_index_in;

   // Output register.
   logic               rsp_valid_ff;
   fldt_pkg::rsp_type  rsp_ff, rsp_in;

   // Control signals.
   logic                req_fire;
   logic                out_free;
   logic                match;
   logic                last_cmp;
   logic                read_in_range;
   logic                table_full;
   logic                mem_re;
   logic                mem_we;
   logic                load_rsp;
   logic [IDX_W-1:0]    rd_addr;
   logic [IDX_W-1:0]    wr_addr;
   fldt_pkg::entry_type wr_data;
   logic [fldt_pkg::COUNT_W-1:0] count_next;

   // Handshake and shared compare logic.
   assign req_if.ready  = (state_ff == fldt_pkg::ST_IDLE);
   assign req_fire      = req_if.valid && req_if.ready;
   assign out_free      = !rsp_valid_ff || rsp_if.ready;
   assign match         = (rd_data_ff.tuple == key_ff);
   assign last_cmp      = ((FILL_W'(cmp_idx_ff) + FILL_W'(1)) == fill_ff);
   assign read_in_range = (CMP_W'(ridx_ff) < CMP_W'(fill_ff));
   assign table_full    = (fill_ff == FILL_W'(CAPACITY));
   assign count_next    = (&rd_data_ff.count) ? rd_data_ff.count
                                              : rd_data_ff.count + 1'b1;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fldt_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = fldt_pkg::ST_DISPATCH;
            end
         end
         fldt_pkg::ST_DISPATCH: begin
            case (mode_ff)
               fldt_pkg::MODE_RECORD: begin
                  state_in = (fill_ff == '0) ? fldt_pkg::ST_APPEND : fldt_pkg::ST_SEARCH;
               end
               fldt_pkg::MODE_READ: begin
                  state_in = read_in_range ? fldt_pkg::ST_READ_OUT : fldt_pkg::ST_BLANK;
               end
               fldt_pkg::MODE_CLEAR: begin
                  state_in = fldt_pkg::ST_BLANK;
               end
               default: begin
                  state_in = fldt_pkg::ST_IDLE;
               end
            endcase
         end
         fldt_pkg::ST_SEARCH: begin
            if (cmp_valid_ff && match) begin
               state_in = fldt_pkg::ST_MERGE;
            end else if (cmp_valid_ff && last_cmp) begin
               state_in = fldt_pkg::ST_APPEND;
            end
         end
         fldt_pkg::ST_MERGE, fldt_pkg::ST_APPEND, fldt_pkg::ST_READ_OUT,
         fldt_pkg::ST_BLANK: begin
            if (out_free) begin
               state_in = fldt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fldt_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath control for each state.
   always_comb begin
      fill_in       = fill_ff;
      scan_in       = scan_ff;
      cmp_idx_in    = cmp_idx_ff;
      cmp_valid_in  = 1'b0;
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      mem_re        = 1'b0;
      mem_we        = 1'b0;
      rd_addr       = scan_ff[IDX_W-1:0];
      wr_addr       = cmp_idx_ff;
      wr_data       = rd_data_ff;
      load_rsp      = 1'b0;
      rsp_in        = rsp_ff;
      case (state_ff)
         fldt_pkg::ST_DISPATCH: begin
            scan_in = '0;
            case (mode_ff)
               fldt_pkg::MODE_READ: begin
                  mem_re        = read_in_range;
                  rd_addr       = IDX_W'(ridx_ff);
                  res_status_in = fldt_pkg::STATUS_READ_EMPTY;
                  res_index_in  = ridx_ff;
               end
               fldt_pkg::MODE_CLEAR: begin
                  fill_in       = '0;
                  res_status_in = fldt_pkg::STATUS_CLEARED;
                  res_index_in  = '0;
               end
               default: begin
                  res_status_in = res_status_ff;
               end
            endcase
         end
         fldt_pkg::ST_SEARCH: begin
            // Issue one read per cycle; stop as soon as a hit shows up.
            if ((scan_ff < fill_ff) && !(cmp_valid_ff && match)) begin
               mem_re       = 1'b1;
               cmp_valid_in = 1'b1;
               cmp_idx_in   = scan_ff[IDX_W-1:0];
               scan_in      = scan_ff + 1'b1;
            end
         end
         fldt_pkg::ST_MERGE: begin
            wr_addr           = cmp_idx_ff;
            wr_data           = rd_data_ff;
            wr_data.timestamp = ts_ff;
            wr_data.count     = count_next;
            if (out_free) begin
               mem_we             = 1'b1;
               load_rsp           = 1'b1;
               rsp_in.status      = fldt_pkg::STATUS_MERGED;
               rsp_in.entry_index = fldt_pkg::RIDX_W'(cmp_idx_ff);
               rsp_in.entry       = wr_data;
            end
         end
         fldt_pkg::ST_APPEND: begin
            wr_addr         = fill_ff[IDX_W-1:0];
            wr_data.tuple     = key_ff;
            wr_data.timestamp = ts_ff;
            wr_data.count     = fldt_pkg::COUNT_W'(1);
            if (out_free) begin
               load_rsp = 1'b1;
               if (table_full) begin
                  rsp_in.status      = fldt_pkg::STATUS_FULL;
                  rsp_in.entry_index = '0;
                  rsp_in.entry       = '0;
               end else begin
                  mem_we             = 1'b1;
                  fill_in            = fill_ff + 1'b1;
                  rsp_in.status      = fldt_pkg::STATUS_NEW;
                  rsp_in.entry_index = fldt_pkg::RIDX_W'(fill_ff[IDX_W-1:0]);
                  rsp_in.entry       = wr_data;
               end
            end
         end
         fldt_pkg::ST_READ_OUT: begin
            if (out_free) begin
               load_rsp           = 1'b1;
               rsp_in.status      = fldt_pkg::STATUS_READ_VALID;
               rsp_in.entry_index = ridx_ff;
               rsp_in.entry       = rd_data_ff;
            end
         end
         fldt_pkg::ST_BLANK: begin
            if (out_free) begin
               load_rsp           = 1'b1;
               rsp_in.status      = res_status_ff;
               rsp_in.entry_index = res_index_ff;
               rsp_in.entry       = '0;
            end
         end
         default: begin
            load_rsp = 1'b0;
         end
      endcase
   end

   // Table memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      if (mem_re) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fldt_pkg::ST_IDLE;
         fill_ff      <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         cmp_valid_ff <= cmp_valid_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      cmp_idx_ff    <= cmp_idx_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      rsp_ff        <= rsp_in;
      if (req_fire) begin
         mode_ff            <= fldt_pkg::mode_type'(req_if.mode);
         key_ff.src_ip      <= req_if.src_ip;
         key_ff.dst_ip      <= req_if.dst_ip;
         key_ff.source_port <= req_if.source_port;
         key_ff.dest_port   <= req_if.dest_port;
         key_ff.protocol    <= req_if.protocol;
         key_ff.action      <= req_if.action;
         key_ff.reason      <= req_if.reason;
         ts_ff              <= req_if.timestamp;
         ridx_ff            <= req_if.read_index;
      end
   end

   // Response channel.
   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.status          = rsp_ff.status;
   assign rsp_if.entry_index     = rsp_ff.entry_index;
   assign rsp_if.out_src_ip      = rsp_ff.entry.tuple.src_ip;
   assign rsp_if.out_dst_ip      = rsp_ff.entry.tuple.dst_ip;
   assign rsp_if.out_source_port = rsp_ff.entry.tuple.source_port;
   assign rsp_if.out_dest_port   = rsp_ff.entry.tuple.dest_port;
   assign rsp_if.out_protocol    = rsp_ff.entry.tuple.protocol;
   assign rsp_if.out_action      = rsp_ff.entry.tuple.action;
   assign rsp_if.out_reason      = rsp_ff.entry.tuple.reason;
   assign rsp_if.out_timestamp   = rsp_ff.entry.timestamp;
   assign rsp_if.out_count       = rsp_ff.entry.count;

endmodule
